// ===== sv/beswap_pkg.sv =====
// Shared types and constants for the big-endian region swap unit.
package beswap_pkg;

	localparam int MAX_REGIONS_DEF = 64;

	typedef enum logic [1:0] {
		FN_MARK_NATIVE = 2'd0,
		FN_MARK_BIG    = 2'd1,
		FN_READ        = 2'd2,
		FN_WRITE       = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_WRAP     = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD,
		S_EMIT,
		S_SEARCH,
		S_CMP,
		S_CHECK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [31:0] rstart;
		logic [31:0] rend;
	} region_t;

endpackage

// ===== sv/big_endian_region_swap_unit.sv =====
// Big-endian region table with byte-swapping access path.
//
// Input channel (in_valid / in_stall) carries one word: func, addr, size_bytes,
// data_in. Output channel (out_valid / out_stall) returns one word per input:
// data_out, swapped, status, range_count.
// in_stall is high while a word is in work; one word is processed at a time.
// A read or write access runs a binary search over the table through a single
// memory read port: states SEARCH and CMP for each halving, then CHECK and FIN;
// SEARCH goes straight to FIN when no entry starts at or below addr.
// Bad sizes and wrapping marks go from IDLE straight to FIN.
// A mark streams the held table through the same read port into the other
// bank of the region memory, trimming, splitting and inserting on the way
// through the states FETCH, LOAD and EMIT.
// A mark that would overflow the table or whose end wraps leaves the table
// untouched and reports its status.
// Reset empties the table (count to zero); memory contents are not cleared.
// While out_stall holds a finished word in the output register, the block
// takes one more word, works it, and then waits in its last state with
// in_stall high until the output register frees up.
module big_endian_region_swap_unit #(
	parameter int MAX_REGIONS = beswap_pkg::MAX_REGIONS_DEF,
	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
	localparam int CW = $clog2(MAX_REGIONS + 1),
	localparam int OW = $clog2(MAX_REGIONS + 3)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [31:0]   addr,
	input  logic [31:0]   size_bytes,
	input  logic [31:0]   data_in,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   data_out,
	output logic          swapped,
	output logic [1:0]    status,
	output logic [CW-1:0] range_count
);

	beswap_pkg::state_t state_q, state_nx;

	beswap_pkg::region_t mem [2**(IW+1)];
	beswap_pkg::region_t rd_q;
	logic [IW:0]         rd_addr;
	logic                we;
	logic [IW:0]         wr_addr;
	beswap_pkg::region_t wr_data;

	logic                bank_q;
	logic [CW-1:0]       count_q;
	logic [1:0]          func_q;
	logic [31:0]         lo_q, hi_q, size_q, data_q;
	logic                ins_q;
	logic [CW-1:0]       idx_q;
	logic [OW-1:0]       ocnt_q;
	beswap_pkg::region_t q0_q, q1_q;
	logic [1:0]          qn_q;
	logic [CW-1:0]       a_q, b_q, m_q;
	logic                big_q;
	logic [1:0]          stat_q;
	logic                out_free;
	logic                accept;
	logic [32:0]         mark_end;
	logic                size_ok;
	logic                is_mark;
	logic [CW:0]         mid_sum;
	logic [CW-1:0]       mid;
	logic                use_ins;
	logic [31:0]         mask;
	logic [31:0]         swap_val;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != beswap_pkg::S_IDLE);
	assign mark_end = {1'b0, addr} + {1'b0, size_bytes};
	assign size_ok  = (size_bytes == 32'd1) || (size_bytes == 32'd2) || (size_bytes == 32'd4);
	assign is_mark  = !func_q[1];
	assign mid_sum  = {1'b0, a_q} + {1'b0, b_q};
	assign mid      = mid_sum[CW:1];
	assign use_ins  = ins_q && (q0_q.rstart >= lo_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			beswap_pkg::S_IDLE: begin
				if (accept) begin
					if (!func[1])
						state_nx = mark_end[32] ? beswap_pkg::S_FIN : beswap_pkg::S_FETCH;
					else
						state_nx = size_ok ? beswap_pkg::S_SEARCH : beswap_pkg::S_FIN;
				end
			end
			beswap_pkg::S_FETCH: begin
				if (idx_q != count_q)
					state_nx = beswap_pkg::S_LOAD;
				else if (!ins_q)
					state_nx = beswap_pkg::S_FIN;
			end
			beswap_pkg::S_LOAD: state_nx = beswap_pkg::S_EMIT;
			beswap_pkg::S_EMIT: begin
				if (qn_q == 2'd0)
					state_nx = beswap_pkg::S_FETCH;
			end
			beswap_pkg::S_SEARCH: begin
				if (a_q < b_q)
					state_nx = beswap_pkg::S_CMP;
				else if (a_q == '0)
					state_nx = beswap_pkg::S_FIN;
				else
					state_nx = beswap_pkg::S_CHECK;
			end
			beswap_pkg::S_CMP:   state_nx = beswap_pkg::S_SEARCH;
			beswap_pkg::S_CHECK: state_nx = beswap_pkg::S_FIN;
			beswap_pkg::S_FIN: begin
				if (out_free)
					state_nx = beswap_pkg::S_IDLE;
			end
			default: state_nx = beswap_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		rd_addr = {bank_q, idx_q[IW-1:0]};
		we      = 1'b0;
		wr_data = q0_q;
		unique case (state_q)
			beswap_pkg::S_FETCH: begin
				if (idx_q == count_q && ins_q) begin
					we      = 1'b1;
					wr_data = '{rstart: lo_q, rend: hi_q};
				end
			end
			beswap_pkg::S_EMIT: begin
				if (qn_q != 2'd0) begin
					we      = 1'b1;
					wr_data = use_ins ? '{rstart: lo_q, rend: hi_q} : q0_q;
				end
			end
			beswap_pkg::S_SEARCH: begin
				if (a_q < b_q)
					rd_addr = {bank_q, mid[IW-1:0]};
				else
					rd_addr = {bank_q, IW'(a_q - CW'(1))};
			end
			default: ;
		endcase
		if (ocnt_q >= OW'(MAX_REGIONS))
			we = 1'b0;
	end
	assign wr_addr = {~bank_q, ocnt_q[IW-1:0]};

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		unique case (size_q[2:0])
			3'd4:    mask = 32'hFFFF_FFFF;
			3'd2:    mask = 32'h0000_FFFF;
			default: mask = 32'h0000_00FF;
		endcase
		unique case (size_q[2:0])
			3'd4:    swap_val = {data_q[7:0], data_q[15:8], data_q[23:16], data_q[31:24]};
			3'd2:    swap_val = {16'h0, data_q[7:0], data_q[15:8]};
			default: swap_val = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= beswap_pkg::S_IDLE;
			bank_q    <= 1'b0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == beswap_pkg::S_FIN && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (state_q == beswap_pkg::S_FETCH && idx_q == count_q && !ins_q &&
			    ocnt_q <= OW'(MAX_REGIONS)) begin
				bank_q  <= ~bank_q;
				count_q <= ocnt_q[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			beswap_pkg::S_IDLE: begin
				if (accept) begin
					func_q <= func;
					lo_q   <= addr;
					hi_q   <= mark_end[31:0];
					size_q <= size_bytes;
					data_q <= data_in;
					ins_q  <= (func == beswap_pkg::FN_MARK_BIG);
					idx_q  <= '0;
					ocnt_q <= '0;
					qn_q   <= 2'd0;
					a_q    <= '0;
					b_q    <= count_q;
					big_q  <= 1'b0;
					if (!func[1])
						stat_q <= mark_end[32] ? beswap_pkg::ST_WRAP : beswap_pkg::ST_OK;
					else
						stat_q <= size_ok ? beswap_pkg::ST_OK : beswap_pkg::ST_BAD_SIZE;
				end
			end
			beswap_pkg::S_FETCH: begin
				if (idx_q != count_q) begin
					idx_q <= idx_q + CW'(1);
				end else if (ins_q) begin
					ins_q  <= 1'b0;
					ocnt_q <= ocnt_q + OW'(1);
				end else if (ocnt_q > OW'(MAX_REGIONS)) begin
					stat_q <= beswap_pkg::ST_FULL;
				end
			end
			beswap_pkg::S_LOAD: begin
				// trim the held range against the mark
				if (hi_q <= rd_q.rstart || lo_q >= rd_q.rend) begin
					q0_q <= rd_q;
					qn_q <= 2'd1;
				end else if (lo_q <= rd_q.rstart && hi_q >= rd_q.rend) begin
					qn_q <= 2'd0;
				end else if (lo_q > rd_q.rstart && hi_q < rd_q.rend) begin
					q0_q <= '{rstart: rd_q.rstart, rend: lo_q};
					q1_q <= '{rstart: hi_q, rend: rd_q.rend};
					qn_q <= 2'd2;
				end else if (lo_q <= rd_q.rstart) begin
					q0_q <= '{rstart: hi_q, rend: rd_q.rend};
					qn_q <= 2'd1;
				end else begin
					q0_q <= '{rstart: rd_q.rstart, rend: lo_q};
					qn_q <= 2'd1;
				end
			end
			beswap_pkg::S_EMIT: begin
				if (qn_q != 2'd0) begin
					ocnt_q <= ocnt_q + OW'(1);
					if (use_ins) begin
						ins_q <= 1'b0;
					end else begin
						q0_q <= q1_q;
						qn_q <= qn_q - 2'd1;
					end
				end
			end
			beswap_pkg::S_SEARCH: m_q <= mid;
			beswap_pkg::S_CMP: begin
				if (rd_q.rstart <= lo_q)
					a_q <= m_q + CW'(1);
				else
					b_q <= m_q;
			end
			beswap_pkg::S_CHECK: begin
				big_q <= (lo_q >= rd_q.rstart) &&
				         (({1'b0, lo_q} + {1'b0, size_q}) <= {1'b0, rd_q.rend});
			end
			beswap_pkg::S_FIN: begin
				if (out_free) begin
					status      <= stat_q;
					range_count <= count_q;
					if (is_mark || stat_q != beswap_pkg::ST_OK) begin
						data_out <= '0;
						swapped  <= 1'b0;
					end else begin
						data_out <= (big_q ? swap_val : data_q) & mask;
						swapped  <= big_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
